/* hw/rtl/mht_pkg.sv */
// Shared types and constants for the modulo hash table.
// Field widths, operation and status codes, and the slot layout of one bucket row.
// No dependencies.
package mht_pkg;

  localparam int KEY_W     = 64;
  localparam int HANDLE_W  = 16;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int BCNT_W    = 9;
  localparam int KEY_BYTES = KEY_W / 8;
  localparam int BYTE_CNT_W = $clog2(KEY_BYTES);

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_FIND   = 2'd1;
  localparam mode_t MODE_REMOVE = 2'd2;
  localparam mode_t MODE_NOP    = 2'd3;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_DUP     = 2'd1;
  localparam status_t ST_MISSING = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } slot_t;

endpackage

/* hw/rtl/mht_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters. No dependencies.
module mht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/mht_mod.sv */
// Iterative remainder unit: 64-bit key modulo a 9-bit divisor, one key byte per cycle.
// Depends on mht_pkg for the key and count widths.
module mht_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mht_pkg::KEY_W-1:0]   key,
  input  logic [mht_pkg::BCNT_W-1:0]  divisor,
  output logic                        done,
  output logic [mht_pkg::BCNT_W-1:0]  rem
);

  import mht_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [BYTE_CNT_W-1:0] cnt_r;
  logic [KEY_W-1:0]      key_r;
  logic [BCNT_W-1:0]     rem_r;
  logic [BCNT_W-1:0]     rem_nxt;

  // Fold the top key byte into the partial remainder, one bit at a time.
  always_comb begin
    logic [BCNT_W:0] t;
    rem_nxt = rem_r;
    for (int b = 7; b >= 0; b--) begin
      t = {rem_nxt, key_r[KEY_W-8+b]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      rem_nxt = t[BCNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        key_r  <= key;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        key_r <= {key_r[KEY_W-9:0], 8'h00};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == BYTE_CNT_W'(KEY_BYTES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* hw/rtl/modulo_hash_table.sv */
// Top level of the modulo hash table: control sequencer, bucket row compare and update.
// Depends on mht_pkg, mht_ram (bucket rows) and mht_mod (bucket index).
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_mode, in_key, in_handle
//   out_     output     out_valid / out_ready  out_found, out_found_handle, out_status
//   cfg_     input      cfg_we                 cfg_wdata (bucket count)
//
// Each insert, find or remove runs the key through the remainder unit (one key byte
// each step), then a row read, compare and write back. A no-op request skips both.
// After reset a clearing pass writes every bucket row once; in_ready stays low
// until it ends. A finished result waits in the output register; the next
// request is taken meanwhile and holds only at its own end.
module modulo_hash_table #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mht_pkg::MODE_W-1:0]     in_mode,
  input  logic [mht_pkg::KEY_W-1:0]      in_key,
  input  logic [mht_pkg::HANDLE_W-1:0]   in_handle,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_found,
  output logic [mht_pkg::HANDLE_W-1:0]   out_found_handle,
  output logic [mht_pkg::STATUS_W-1:0]   out_status,
  input  logic                           cfg_we,
  input  logic [mht_pkg::BCNT_W-1:0]     cfg_wdata
);

  import mht_pkg::*;

  localparam int AW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W  = WAYS * $bits(slot_t);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MOD, S_EVAL, S_DONE} state_t;

  state_t                state_r;
  logic [AW-1:0]         clr_cnt_r;
  logic [BCNT_W-1:0]     bucket_count_r;
  logic [BCNT_W-1:0]     eff_count;
  logic [BCNT_W-1:0]     div_r;
  mode_t                 mode_r;
  logic [KEY_W-1:0]      key_r;
  logic [HANDLE_W-1:0]   handle_r;
  logic [AW-1:0]         bidx_r;

  logic                  res_found_r;
  logic [HANDLE_W-1:0]   res_handle_r;
  status_t               res_status_r;

  logic                  out_valid_r;
  logic                  out_found_r;
  logic [HANDLE_W-1:0]   out_handle_r;
  status_t               out_status_r;

  logic                  accept;
  logic                  mod_done;
  logic [BCNT_W-1:0]     mod_rem;
  logic [AW-1:0]         bidx;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [ROW_W-1:0]      ram_rdata;

  slot_t [WAYS-1:0]      row;
  slot_t [WAYS-1:0]      row_nxt;
  logic                  row_mod;
  logic                  hit;
  logic                  has_free;
  logic [WW-1:0]         hit_way;
  logic [WW-1:0]         free_way;
  logic [HANDLE_W-1:0]   hit_handle;
  status_t               status_nxt;

  // Zero acts as one bucket; counts above the table size saturate.
  always_comb begin
    if (bucket_count_r == '0) begin
      eff_count = BCNT_W'(1);
    end else if (32'(bucket_count_r) > BUCKETS) begin
      eff_count = BCNT_W'(BUCKETS);
    end else begin
      eff_count = bucket_count_r;
    end
  end

  assign accept = in_valid && (state_r == S_IDLE);
  assign bidx   = AW'(mod_rem);

  mht_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept && (in_mode != MODE_NOP)),
    .key     (in_key),
    .divisor (div_r),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // Compare all ways of the row; lowest matching way and lowest free way win.
  assign row = ram_rdata;

  always_comb begin
    hit      = 1'b0;
    has_free = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row[w].valid) begin
        if (!hit && (row[w].key == key_r)) begin
          hit     = 1'b1;
          hit_way = WW'(w);
        end
      end else if (!has_free) begin
        has_free = 1'b1;
        free_way = WW'(w);
      end
    end
  end

  assign hit_handle = hit ? row[hit_way].handle : '0;

  always_comb begin
    row_nxt    = row;
    row_mod    = 1'b0;
    status_nxt = ST_OK;
    case (mode_r)
      MODE_INSERT: begin
        if (hit) begin
          status_nxt = ST_DUP;
        end else if (has_free) begin
          row_nxt[free_way].valid  = 1'b1;
          row_nxt[free_way].key    = key_r;
          row_nxt[free_way].handle = handle_r;
          row_mod                  = 1'b1;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      MODE_REMOVE: begin
        if (hit) begin
          row_nxt[hit_way].valid = 1'b0;
          row_mod                = 1'b1;
        end else begin
          status_nxt = ST_MISSING;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Clearing pass owns the write port after reset; otherwise write back on update.
  always_comb begin
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_r == S_EVAL) && row_mod;
      ram_waddr = bidx_r;
      ram_wdata = row_nxt;
    end
  end

  assign ram_re = (state_r == S_MOD) && mod_done;

  mht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (bidx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      bucket_count_r <= BCNT_W'(256);
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        bucket_count_r <= cfg_wdata;
      end
      // S_DONE drives the output register itself.
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == AW'(BUCKETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            mode_r   <= in_mode;
            key_r    <= in_key;
            handle_r <= in_handle;
            div_r    <= eff_count;
            if (in_mode == MODE_NOP) begin
              res_found_r  <= 1'b0;
              res_handle_r <= '0;
              res_status_r <= ST_OK;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            bidx_r  <= bidx;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_found_r  <= hit;
          res_handle_r <= hit_handle;
          res_status_r <= status_nxt;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_found_r  <= res_found_r;
            out_handle_r <= res_handle_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_found_handle = out_handle_r;
  assign out_status       = out_status_r;

endmodule

/* tb/mht_checker.sv */
`timescale 1ns / 100ps
// Checker for the modulo hash table: predicts each request's result and compares it.
// Depends on mht_pkg; watches the request, result and bucket count ports of the block.
module mht_checker #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [mht_pkg::MODE_W-1:0]     in_mode,
  input  logic [mht_pkg::KEY_W-1:0]      in_key,
  input  logic [mht_pkg::HANDLE_W-1:0]   in_handle,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_found,
  input  logic [mht_pkg::HANDLE_W-1:0]   out_found_handle,
  input  logic [mht_pkg::STATUS_W-1:0]   out_status,
  input  logic                           cfg_we,
  input  logic [mht_pkg::BCNT_W-1:0]     cfg_wdata,
  output int                             fail_count,
  output int                             checked_count
);
  import mht_pkg::*;

  localparam int SLOTS = BUCKETS * WAYS;

  typedef struct packed {
    logic                found;
    logic [HANDLE_W-1:0] fhandle;
    status_t             status;
  } lookup_t;

  logic                tbl_valid [SLOTS];
  logic [KEY_W-1:0]    tbl_key   [SLOTS];
  logic [HANDLE_W-1:0] tbl_handle[SLOTS];
  logic [BCNT_W-1:0]   bucket_cfg;
  lookup_t             lookup_q[$];
  int                  mismatches = 0;
  int                  results_seen = 0;

  // Look up the key in its bucket row, apply the operation to the mirror table.
  task automatic apply_op(input mode_t mode, input logic [KEY_W-1:0] key,
                          input logic [HANDLE_W-1:0] hnd, output lookup_t res);
    logic [KEY_W-1:0] n;
    int               base;
    int               hit_way;
    int               free_way;
    bit               hit;
    bit               has_free;
    res      = '0;
    hit      = 0;
    has_free = 0;
    hit_way  = 0;
    free_way = 0;
    if (mode != MODE_NOP) begin
      n = KEY_W'(bucket_cfg);
      if (n == 0) n = KEY_W'(1);
      if (n > KEY_W'(BUCKETS)) n = KEY_W'(BUCKETS);
      base = int'(key % n) * WAYS;
      for (int w = 0; w < WAYS; w++) begin
        if (tbl_valid[base + w]) begin
          if (!hit && tbl_key[base + w] == key) begin
            hit     = 1;
            hit_way = w;
          end
        end else if (!has_free) begin
          has_free = 1;
          free_way = w;
        end
      end
      if (hit) begin
        res.found   = 1'b1;
        res.fhandle = tbl_handle[base + hit_way];
      end
      res.status = ST_OK;
      case (mode)
        MODE_INSERT: begin
          if (hit) begin
            res.status = ST_DUP;
          end else if (has_free) begin
            tbl_valid[base + free_way]  = 1'b1;
            tbl_key[base + free_way]    = key;
            tbl_handle[base + free_way] = hnd;
          end else begin
            res.status = ST_FULL;
          end
        end
        MODE_REMOVE: begin
          if (hit) tbl_valid[base + hit_way] = 1'b0;
          else res.status = ST_MISSING;
        end
        default: ;
      endcase
    end
  endtask

  function automatic void report(input string field, input logic [HANDLE_W-1:0] exp_v,
                                 input logic [HANDLE_W-1:0] act_v);
    mismatches++;
    // limit log size on a badly broken run
    if (mismatches <= 100)
      $display("%0t: %s expected %0h actual %0h", $time, field, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    lookup_t res;
    lookup_t exp_r;
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
      bucket_cfg = 9'd256;
      lookup_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (lookup_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 100)
            $display("%0t: result with no request waiting, expected none actual %0h/%0h/%0h",
                     $time, out_found, out_found_handle, out_status);
        end else begin
          exp_r = lookup_q.pop_front();
          if (out_found !== exp_r.found)
            report("found", HANDLE_W'(exp_r.found), HANDLE_W'(out_found));
          if (out_found_handle !== exp_r.fhandle)
            report("found_handle", exp_r.fhandle, out_found_handle);
          if (out_status !== exp_r.status)
            report("status", HANDLE_W'(exp_r.status), HANDLE_W'(out_status));
        end
      end
      if (in_valid && in_ready) begin
        apply_op(mode_t'(in_mode), in_key, in_handle, res);
        lookup_q.push_back(res);
      end
      if (cfg_we) bucket_cfg = cfg_wdata;
    end
    fail_count    <= mismatches;
    checked_count <= results_seen;
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Top of the modulo hash table testbench: clock, reset, request and bucket count stimulus.
// Depends on mht_pkg, modulo_hash_table and mht_checker, which gives the verdict its count.
module tb_top;
  import mht_pkg::*;

  localparam int BUCKETS = 256;
  localparam int WAYS    = 4;
  localparam int PHASE_REQS = 125;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  mode_t               in_mode = MODE_FIND;
  logic [KEY_W-1:0]    in_key = '0;
  logic [HANDLE_W-1:0] in_handle = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_found;
  logic [HANDLE_W-1:0] out_found_handle;
  status_t             out_status;
  logic                cfg_we = 1'b0;
  logic [BCNT_W-1:0]   cfg_wdata = '0;

  int fail_count;
  int checked_count;
  int sent_count = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_cyc = 0;

  modulo_hash_table #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_key(in_key), .in_handle(in_handle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_found(out_found), .out_found_handle(out_found_handle), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  mht_checker #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_key(in_key), .in_handle(in_handle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_found(out_found), .out_found_handle(out_found_handle), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .checked_count(checked_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: drive out_ready from a stall pattern that is switched at random.
  always @(posedge clk) begin
    if (stall_cyc % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((stall_cyc % 9) < 3);
    endcase
    stall_cyc = stall_cyc + 1;
  end

  function automatic int unsigned buckets_in_use(input int unsigned v);
    if (v == 0) return 1;
    if (v > BUCKETS) return BUCKETS;
    return v;
  endfunction

  // Move a random key into bucket t under n buckets, keeping its upper bits.
  function automatic logic [KEY_W-1:0] key_in_bucket(input logic [KEY_W-1:0] raw,
                                                     input int unsigned n,
                                                     input int unsigned t);
    logic [KEY_W-1:0] floor_k;
    logic [KEY_W-1:0] kb;
    floor_k = raw - (raw % n);
    kb = floor_k + t;
    if (kb < floor_k) kb = kb - n;
    return kb;
  endfunction

  task automatic send_req(input mode_t mode, input logic [KEY_W-1:0] key,
                          input logic [HANDLE_W-1:0] hnd);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 80);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 8);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_mode   <= mode;
    in_key    <= key;
    in_handle <= hnd;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // Drop valid and hold until every request has its result back.
  task automatic drain();
    in_valid <= 1'b0;
    while (checked_count != sent_count) @(posedge clk);
  endtask

  task automatic write_bucket_count(input int unsigned v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[BCNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned phase_cfg[10];
    int unsigned n;
    int unsigned targets[3];
    logic [KEY_W-1:0] pool[16];
    logic [KEY_W-1:0] key;
    mode_t mode;
    int r;
    phase_cfg = '{1, 0, 511, 2, 257, 3, 256, 17, 100, 255};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_bucket_count(256);

    // Directed: key extremes, duplicate, full bucket, remove of a missing key, no-op.
    send_req(MODE_INSERT, '0, 16'h0000);
    send_req(MODE_INSERT, KEY_MAX, 16'hFFFF);
    send_req(MODE_FIND, '0, 16'hFFFF);
    send_req(MODE_FIND, KEY_MAX, 16'h0000);
    send_req(MODE_INSERT, '0, 16'h1234);
    for (int i = 0; i < 5; i++)
      send_req(MODE_INSERT, 64'd5 + 64'd256 * i, 16'(16'h0100 + i));
    send_req(MODE_FIND, 64'd517, 16'h0000);
    send_req(MODE_REMOVE, 64'd261, 16'h0000);
    send_req(MODE_REMOVE, 64'd261, 16'h0000);
    send_req(MODE_INSERT, 64'd1029, 16'hBEEF);
    send_req(MODE_FIND, 64'd1029, 16'h0000);
    send_req(MODE_FIND, 64'd9, 16'h0000);
    send_req(MODE_NOP, KEY_MAX, 16'hFFFF);
    send_req(MODE_NOP, '0, 16'h0000);
    send_req(MODE_REMOVE, '0, 16'h0000);
    send_req(MODE_FIND, '0, 16'h0000);
    send_req(MODE_REMOVE, KEY_MAX, 16'h0000);
    send_req(MODE_REMOVE, KEY_MAX, 16'h0000);
    drain();

    // Random phases; old keys stay stored across bucket count changes.
    foreach (phase_cfg[p]) begin
      write_bucket_count(phase_cfg[p]);
      n = buckets_in_use(phase_cfg[p]);
      foreach (targets[t]) targets[t] = $urandom_range(0, n - 1);
      foreach (pool[i]) pool[i] = key_in_bucket({$urandom, $urandom}, n, targets[i % 3]);
      for (int i = 0; i < PHASE_REQS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          mode = mode_t'($urandom_range(0, 3));
          key  = {$urandom, $urandom};
        end else begin
          key = pool[$urandom_range(0, 15)];
          r = $urandom_range(0, 99);
          if (r < 45) mode = MODE_INSERT;
          else if (r < 65) mode = MODE_FIND;
          else if (r < 88) mode = MODE_REMOVE;
          else mode = MODE_NOP;
        end
        send_req(mode, key, 16'($urandom_range(0, 16'hFFFF)));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
